[rtl/art_pkg.sv]
// Shared types and constants for the address range table.
// Used by art_ctrl, art_dp and address_range_table_top; no dependencies.
`timescale 1ns / 1ps

package art_pkg;

  localparam int ENTRIES     = 32;
  localparam int ADDR_BITS   = 48;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_BITS    = $clog2(ENTRIES);
  localparam int TOTAL_BITS  = ADDR_BITS + 1;
  localparam int CMD_BITS    = 3;
  localparam int STATUS_BITS = 3;

  localparam int IN_BITS         = CMD_BITS + 2 * ADDR_BITS + HANDLE_BITS;
  localparam int IN_TDATA_BITS   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS        = STATUS_BITS + HANDLE_BITS + 2 * ADDR_BITS + TOTAL_BITS;
  localparam int OUT_TDATA_BITS  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_ERASE   = 3'd1,
    CMD_RESOLVE = 3'd2,
    CMD_TOTAL   = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_OVL_NEXT  = 3'd2,
    ST_OVL_PREV  = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0]   base;
    logic [ADDR_BITS-1:0]   size;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic                start;
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_idx;
    logic                commit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

[rtl/address_range_table_top.sv]
// Top level of the address range table: stream ports, controller and datapath.
// Depends on art_pkg, art_ctrl and art_dp.
//
//   channel   dir  beat contents (low bit first)
//   s_axis    in   command[2:0], address[50:3], length[98:51], handle[114:99]
//   m_axis    out  status[2:0], found_handle[18:3], offset[66:19],
//                  remaining[114:67], total_size[163:115]
//
// Insert, erase, resolve and total walk all 32 slots through the entry
// memory's single registered read port: the beat is accepted, each slot is
// read in turn, the read stage drains and the result is committed. Clear and
// unknown commands skip the scan. A new command beat is taken as soon as the
// previous result is committed to the output register, even while m_axis is
// stalled; the commit of the next result holds until that register is free.
// Reset clears the valid bits, the controller and the output flag at once.
`timescale 1ns / 1ps

module address_range_table_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // command, address, length, handle; zero padded to whole bytes
  input  logic [art_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // status, found_handle, offset, remaining, total_size; zero padded
  output logic [art_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata
);

  localparam int AB = art_pkg::ADDR_BITS;
  localparam int HB = art_pkg::HANDLE_BITS;
  localparam int CB = art_pkg::CMD_BITS;

  art_pkg::ctrl_cmd_t                 ctrl_cmd;
  art_pkg::dp_status_t                dp_status;
  logic [CB-1:0]                      in_cmd;
  logic [AB-1:0]                      in_address;
  logic [AB-1:0]                      in_length;
  logic [HB-1:0]                      in_handle;
  logic [art_pkg::STATUS_BITS-1:0]    out_status;
  logic [HB-1:0]                      out_found_handle;
  logic [AB-1:0]                      out_offset;
  logic [AB-1:0]                      out_remaining;
  logic [art_pkg::TOTAL_BITS-1:0]     out_total_size;

  // Unpack the command beat.
  assign in_cmd     = s_axis_tdata[CB-1:0];
  assign in_address = s_axis_tdata[CB +: AB];
  assign in_length  = s_axis_tdata[CB + AB +: AB];
  assign in_handle  = s_axis_tdata[CB + 2 * AB +: HB];

  art_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (in_cmd),
    .in_ready_o  (s_axis_tready),
    .dp_status_i (dp_status),
    .ctrl_cmd_o  (ctrl_cmd)
  );

  art_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_cmd_i         (ctrl_cmd),
    .dp_status_o        (dp_status),
    .in_cmd_i           (in_cmd),
    .in_address_i       (in_address),
    .in_length_i        (in_length),
    .in_handle_i        (in_handle),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .out_status_o       (out_status),
    .out_found_handle_o (out_found_handle),
    .out_offset_o       (out_offset),
    .out_remaining_o    (out_remaining),
    .out_total_size_o   (out_total_size)
  );

  // Pack the result beat, padding the top with zeros.
  assign m_axis_tdata = {
    {(art_pkg::OUT_TDATA_BITS - art_pkg::OUT_BITS){1'b0}},
    out_total_size,
    out_remaining,
    out_offset,
    out_found_handle,
    out_status
  };

endmodule

[rtl/art_ctrl.sv]
// Sequencer for the address range table: accept, table scan, drain, commit.
// Depends on art_pkg.
`timescale 1ns / 1ps

module art_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [art_pkg::CMD_BITS-1:0]  in_cmd_i,
  output logic                          in_ready_o,
  input  art_pkg::dp_status_t           dp_status_i,
  output art_pkg::ctrl_cmd_t            ctrl_cmd_o
);

  art_pkg::state_e               state_q, state_d;
  logic [art_pkg::IDX_BITS-1:0]  idx_q, idx_d;
  logic                          needs_scan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= art_pkg::S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Clear and unknown commands need no pass over the table.
  assign needs_scan = (in_cmd_i == art_pkg::CMD_INSERT)  ||
                      (in_cmd_i == art_pkg::CMD_ERASE)   ||
                      (in_cmd_i == art_pkg::CMD_RESOLVE) ||
                      (in_cmd_i == art_pkg::CMD_TOTAL);

  always_comb begin
    state_d           = state_q;
    idx_d             = idx_q;
    in_ready_o        = 1'b0;
    ctrl_cmd_o        = '0;
    ctrl_cmd_o.rd_idx = idx_q;
    case (state_q)
      art_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_cmd_o.start = 1'b1;
          idx_d            = '0;
          state_d          = needs_scan ? art_pkg::S_SCAN : art_pkg::S_FINISH;
        end
      end
      art_pkg::S_SCAN: begin
        ctrl_cmd_o.rd_en = 1'b1;
        if (idx_q == art_pkg::IDX_BITS'(art_pkg::ENTRIES - 1)) begin
          state_d = art_pkg::S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      art_pkg::S_DRAIN: begin
        state_d = art_pkg::S_FINISH;
      end
      art_pkg::S_FINISH: begin
        if (dp_status_i.out_free) begin
          ctrl_cmd_o.commit = 1'b1;
          state_d           = art_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = art_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/art_dp.sv]
// Datapath of the address range table: entry memory, valid bits, scan
// accumulators, result decision and output register. Depends on art_pkg.
`timescale 1ns / 1ps

module art_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  art_pkg::ctrl_cmd_t                 ctrl_cmd_i,
  output art_pkg::dp_status_t                dp_status_o,
  input  logic [art_pkg::CMD_BITS-1:0]       in_cmd_i,
  input  logic [art_pkg::ADDR_BITS-1:0]      in_address_i,
  input  logic [art_pkg::ADDR_BITS-1:0]      in_length_i,
  input  logic [art_pkg::HANDLE_BITS-1:0]    in_handle_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [art_pkg::STATUS_BITS-1:0]    out_status_o,
  output logic [art_pkg::HANDLE_BITS-1:0]    out_found_handle_o,
  output logic [art_pkg::ADDR_BITS-1:0]      out_offset_o,
  output logic [art_pkg::ADDR_BITS-1:0]      out_remaining_o,
  output logic [art_pkg::TOTAL_BITS-1:0]     out_total_size_o
);

  localparam int AB = art_pkg::ADDR_BITS;
  localparam int HB = art_pkg::HANDLE_BITS;
  localparam int IB = art_pkg::IDX_BITS;
  localparam int TB = art_pkg::TOTAL_BITS;

  // current item
  logic [art_pkg::CMD_BITS-1:0] cmd_q;
  logic [AB-1:0]                addr_q;
  logic [AB-1:0]                len_q;
  logic [HB-1:0]                hdl_q;

  // table
  art_pkg::entry_t              mem_q [art_pkg::ENTRIES];
  logic [art_pkg::ENTRIES-1:0]  valid_q;

  // read stage
  logic                         rd_ok_q;
  logic [IB-1:0]                rd_idx_q;
  logic                         rd_vld_q;
  art_pkg::entry_t              rd_entry_q;

  // scan accumulators
  logic                         free_found_q;
  logic [IB-1:0]                free_idx_q;
  logic                         nxt_found_q;
  logic [AB-1:0]                nxt_base_q;
  logic                         prv_found_q;
  logic [AB-1:0]                prv_base_q;
  logic [AB-1:0]                prv_size_q;
  logic                         hit_found_q;
  logic [IB-1:0]                hit_idx_q;
  logic                         best_found_q;
  logic [AB-1:0]                best_base_q;
  logic [AB-1:0]                best_size_q;
  logic [HB-1:0]                best_hdl_q;
  logic [TB-1:0]                sum_q;
  logic [TB:0]                  sum_ext;

  // output register
  logic                         out_valid_q;
  logic [art_pkg::STATUS_BITS-1:0] out_status_q;
  logic [HB-1:0]                out_handle_q;
  logic [AB-1:0]                out_offset_q;
  logic [AB-1:0]                out_remaining_q;
  logic [TB-1:0]                out_total_q;

  // result decision
  art_pkg::status_e             res_status;
  logic [HB-1:0]                res_handle;
  logic [AB-1:0]                res_offset;
  logic [AB-1:0]                res_remaining;
  logic [TB-1:0]                res_total;
  logic                         do_write;
  logic                         do_erase;
  logic                         do_clear;
  logic [AB-1:0]                res_off;

  assign dp_status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.start) begin
      cmd_q  <= in_cmd_i;
      addr_q <= in_address_i;
      len_q  <= in_length_i;
      hdl_q  <= in_handle_i;
    end
  end

  // Entry memory: one registered read port, one write port.
  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.rd_en) begin
      rd_entry_q <= mem_q[ctrl_cmd_i.rd_idx];
      rd_idx_q   <= ctrl_cmd_i.rd_idx;
      rd_vld_q   <= valid_q[ctrl_cmd_i.rd_idx];
    end
    if (do_write) begin
      mem_q[free_idx_q] <= '{base: addr_q, size: len_q, handle: hdl_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
      valid_q <= '0;
    end else begin
      rd_ok_q <= ctrl_cmd_i.rd_en;
      if (do_clear) begin
        valid_q <= '0;
      end else if (do_erase) begin
        valid_q[hit_idx_q] <= 1'b0;
      end else if (do_write) begin
        valid_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // Saturating running total over valid sizes.
  assign sum_ext = {1'b0, sum_q} + (TB + 1)'(rd_entry_q.size);

  // Scan: fold one entry per cycle into the accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_q <= 1'b0;
      nxt_found_q  <= 1'b0;
      prv_found_q  <= 1'b0;
      hit_found_q  <= 1'b0;
      best_found_q <= 1'b0;
      sum_q        <= '0;
    end else if (ctrl_cmd_i.start) begin
      free_found_q <= 1'b0;
      nxt_found_q  <= 1'b0;
      prv_found_q  <= 1'b0;
      hit_found_q  <= 1'b0;
      best_found_q <= 1'b0;
      sum_q        <= '0;
    end else if (rd_ok_q) begin
      if (!rd_vld_q) begin
        if (!free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= rd_idx_q;
        end
      end else begin
        if (rd_entry_q.base >= addr_q) begin
          if (!nxt_found_q || rd_entry_q.base < nxt_base_q) begin
            nxt_found_q <= 1'b1;
            nxt_base_q  <= rd_entry_q.base;
          end
        end else begin
          if (!prv_found_q || rd_entry_q.base > prv_base_q) begin
            prv_found_q <= 1'b1;
            prv_base_q  <= rd_entry_q.base;
            prv_size_q  <= rd_entry_q.size;
          end
        end
        if (!hit_found_q && rd_entry_q.base == addr_q) begin
          hit_found_q <= 1'b1;
          hit_idx_q   <= rd_idx_q;
        end
        if (rd_entry_q.base <= addr_q &&
            (!best_found_q || rd_entry_q.base > best_base_q)) begin
          best_found_q <= 1'b1;
          best_base_q  <= rd_entry_q.base;
          best_size_q  <= rd_entry_q.size;
          best_hdl_q   <= rd_entry_q.handle;
        end
        sum_q <= sum_ext[TB] ? {TB{1'b1}} : sum_ext[TB-1:0];
      end
    end
  end

  assign res_off = addr_q - best_base_q;

  always_comb begin
    res_status    = art_pkg::ST_INVALID;
    res_handle    = '0;
    res_offset    = '0;
    res_remaining = '0;
    res_total     = '0;
    do_write      = 1'b0;
    do_erase      = 1'b0;
    do_clear      = 1'b0;
    case (cmd_q)
      art_pkg::CMD_INSERT: begin
        if (addr_q == '0 || len_q == '0 || hdl_q == '0) begin
          res_status = art_pkg::ST_INVALID;
        end else if (nxt_found_q && len_q > (nxt_base_q - addr_q)) begin
          res_status = art_pkg::ST_OVL_NEXT;
        end else if (prv_found_q && prv_size_q > (addr_q - prv_base_q)) begin
          res_status = art_pkg::ST_OVL_PREV;
        end else if (!free_found_q) begin
          res_status = art_pkg::ST_FULL;
        end else begin
          res_status = art_pkg::ST_OK;
          do_write   = ctrl_cmd_i.commit;
        end
      end
      art_pkg::CMD_ERASE: begin
        if (addr_q == '0) begin
          res_status = art_pkg::ST_INVALID;
        end else if (hit_found_q) begin
          res_status = art_pkg::ST_OK;
          do_erase   = ctrl_cmd_i.commit;
        end else begin
          res_status = art_pkg::ST_NOT_FOUND;
        end
      end
      art_pkg::CMD_RESOLVE: begin
        if (addr_q == '0) begin
          res_status = art_pkg::ST_INVALID;
        end else if (!best_found_q || res_off >= best_size_q) begin
          res_status = art_pkg::ST_NOT_FOUND;
        end else begin
          res_status    = art_pkg::ST_OK;
          res_handle    = best_hdl_q;
          res_offset    = res_off;
          res_remaining = best_size_q - res_off;
        end
      end
      art_pkg::CMD_TOTAL: begin
        res_status = art_pkg::ST_OK;
        res_total  = sum_q;
      end
      art_pkg::CMD_CLEAR: begin
        res_status = art_pkg::ST_OK;
        do_clear   = ctrl_cmd_i.commit;
      end
      default: begin
        res_status = art_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.commit) begin
      out_status_q    <= res_status;
      out_handle_q    <= res_handle;
      out_offset_q    <= res_offset;
      out_remaining_q <= res_remaining;
      out_total_q     <= res_total;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_found_handle_o = out_handle_q;
  assign out_offset_o       = out_offset_q;
  assign out_remaining_o    = out_remaining_q;
  assign out_total_size_o   = out_total_q;

endmodule
